/* design/pnd_pkg.sv */
// ----------------------------------------------------------------------------
// pnd_pkg: shared types and constants for the particle number density block
// Field widths, register indexes, opcodes and the kernel result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pnd_pkg;

	localparam int PARTICLES_DEF = 1024;

	// Fixed field widths
	localparam int IDX_W   = 10;
	localparam int POS_W   = 32;
	localparam int CNT_W   = 11;
	localparam int RAD_W   = 31;
	localparam int DENS_W  = 32;
	localparam int CFG_IDX_W = 1;

	// Kernel arithmetic widths
	localparam int D2_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int NUM_W   = RAD_W + 16;
	localparam int SQRT_STEPS = D2_W / 2;
	localparam int DIV_STEPS  = NUM_W;
	localparam logic [NUM_W-1:0] ONE_Q16 = NUM_W'(65536);

	// Command and register codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECTIVE_RADIUS = 1'b1;
	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(352322);

	// Kernel unit result toward the controller
	typedef struct packed {
		logic             done;
		logic             coincident;
		logic [NUM_W-1:0] weight;
	} kres_t;

endpackage

`default_nettype wire

/* design/particle_number_density_top.sv */
// ----------------------------------------------------------------------------
// particle_number_density_top: particle number density engine
// Position table in RAM, neighbour walk and kernel weight accumulation.
// ----------------------------------------------------------------------------
// Use: pulse start with busy low to transfer one command. opcode OP_WRITE
// stores pos_x/y/z at particle_index and produces no result.
// opcode OP_QUERY walks entries 0 .. particle_count-1 (capped at PARTICLES),
// skipping the queried one, and sums re/dis - 1 over neighbours within the
// effective radius. The sum appears on density, queried_index and saturated
// for one cycle while done is high; the receiver cannot hold it off.
// Query: busy covers setup, the skipped entry, neighbours outside the
// radius box (S_NEXT, S_LOAD), and neighbours inside the box (S_MUL, S_ADD,
// then pnd_kernel); the bit-serial square root and, for neighbours within
// the radius, the bit-serial divider in pnd_kernel dominate. done rises in
// the same cycle that busy drops. The walk stops early once the sum
// saturates or a neighbour coincides with the queried particle.
// busy is high for the whole query; writes keep busy low.
// The user must write configuration (cfg_we, cfg_index, cfg_wdata) only
// while idle; the block does not enforce this. Reset clears the registers
// to count 0 and radius 0.021 m; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_number_density_top #(
	parameter int PARTICLES = pnd_pkg::PARTICLES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              opcode,
	input  wire logic [pnd_pkg::IDX_W-1:0]         particle_index,
	input  wire logic signed [pnd_pkg::POS_W-1:0]  pos_x,
	input  wire logic signed [pnd_pkg::POS_W-1:0]  pos_y,
	input  wire logic signed [pnd_pkg::POS_W-1:0]  pos_z,
	input  wire logic                              cfg_we,
	input  wire logic [pnd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pnd_pkg::RAD_W-1:0]         cfg_wdata,
	output logic                                   done,
	output logic [pnd_pkg::IDX_W-1:0]              queried_index,
	output logic [pnd_pkg::DENS_W-1:0]             density,
	output logic                                   saturated
);

	localparam int AW   = $clog2(PARTICLES);
	localparam int CW   = $clog2(PARTICLES + 1);
	localparam int WIDE = 17;
	localparam int PW   = pnd_pkg::POS_W;
	localparam int SQW  = 2 * pnd_pkg::RAD_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SELF, S_NEXT, S_LOAD, S_MUL, S_ADD, S_WAIT, S_DONE
	} state_t;

	state_t                           state_q;
	logic [pnd_pkg::CNT_W-1:0]        count_cfg_q;
	logic [pnd_pkg::RAD_W-1:0]        re_q;
	logic [pnd_pkg::IDX_W-1:0]        idx_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    j_q;
	logic [3*PW-1:0]                  self_q;
	logic [pnd_pkg::DENS_W-1:0]       sum_q;
	logic                             sat_q;
	logic [pnd_pkg::RAD_W-1:0]        dx_s1, dy_s1, dz_s1;
	logic [SQW-1:0]                   sx_s2, sy_s2, sz_s2;
	logic [pnd_pkg::D2_W-1:0]         d2_s3;
	logic                             kstart_q;
	logic                             done_q;
	logic [pnd_pkg::DENS_W-1:0]       density_q;
	logic                             saturated_q;

	logic                             accept;
	logic                             idx_ok;
	logic [CW-1:0]                    count_eff;
	logic [AW-1:0]                    raddr;
	logic [3*PW-1:0]                  rdata;
	logic [PW:0]                      ax, ay, az;
	logic                             near;
	logic [pnd_pkg::NUM_W:0]          acc;
	pnd_pkg::kres_t                   kres;

	// Command decode and address range
	always_comb begin
		accept    = start && !busy;
		idx_ok    = WIDE'(particle_index) < WIDE'(PARTICLES);
		count_eff = (WIDE'(count_cfg_q) > WIDE'(PARTICLES)) ? CW'(PARTICLES)
			: CW'(count_cfg_q);
		raddr     = (state_q == S_IDLE) ? AW'(WIDE'(particle_index)) : j_q[AW-1:0];
	end

	// Position table: {z, y, x} per entry
	pnd_ram #(.WIDTH(3 * PW), .DEPTH(PARTICLES)) u_ram (
		.clk   (clk),
		.we    (accept && opcode == pnd_pkg::OP_WRITE && idx_ok),
		.waddr (AW'(WIDE'(particle_index))),
		.wdata ({pos_z, pos_y, pos_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Per-axis absolute differences against the queried particle
	function automatic logic [PW:0] abs_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic signed [PW:0] d;
		d = $signed({a[PW-1], a}) - $signed({b[PW-1], b});
		return d[PW] ? (~d + 1'b1) : d;
	endfunction

	always_comb begin
		ax   = abs_diff(rdata[PW-1:0], self_q[PW-1:0]);
		ay   = abs_diff(rdata[2*PW-1:PW], self_q[2*PW-1:PW]);
		az   = abs_diff(rdata[3*PW-1:2*PW], self_q[3*PW-1:2*PW]);
		near = (ax < {2'b0, re_q}) && (ay < {2'b0, re_q}) && (az < {2'b0, re_q});
		acc  = (pnd_pkg::NUM_W + 1)'(sum_q) + (pnd_pkg::NUM_W + 1)'(kres.weight);
	end

	pnd_kernel u_kernel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kstart_q),
		.d2     (d2_s3),
		.re     (re_q),
		.res    (kres)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= '0;
			re_q        <= pnd_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pnd_pkg::REG_PARTICLE_COUNT:   count_cfg_q <= cfg_wdata[pnd_pkg::CNT_W-1:0];
				pnd_pkg::REG_EFFECTIVE_RADIUS: re_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Walk neighbours, accumulate weights, present the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kstart_q <= 1'b0;
			done_q   <= 1'b0;
			j_q      <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			sat_q    <= 1'b0;
		end else begin
			kstart_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == pnd_pkg::OP_QUERY) begin
						idx_q   <= particle_index;
						count_q <= count_eff;
						j_q     <= '0;
						sum_q   <= '0;
						sat_q   <= 1'b0;
						state_q <= idx_ok ? S_SELF : S_DONE;
					end
				end
				S_SELF: begin
					self_q  <= rdata;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					priority if (j_q >= count_q) begin
						state_q <= S_DONE;
					end else if (WIDE'(j_q) == WIDE'(idx_q)) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (near) begin
						dx_s1   <= ax[pnd_pkg::RAD_W-1:0];
						dy_s1   <= ay[pnd_pkg::RAD_W-1:0];
						dz_s1   <= az[pnd_pkg::RAD_W-1:0];
						state_q <= S_MUL;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_MUL: begin
					sx_s2   <= SQW'(dx_s1) * SQW'(dx_s1);
					sy_s2   <= SQW'(dy_s1) * SQW'(dy_s1);
					sz_s2   <= SQW'(dz_s1) * SQW'(dz_s1);
					state_q <= S_ADD;
				end
				S_ADD: begin
					d2_s3    <= pnd_pkg::D2_W'(sx_s2) + pnd_pkg::D2_W'(sy_s2)
						+ pnd_pkg::D2_W'(sz_s2);
					kstart_q <= 1'b1;
					state_q  <= S_WAIT;
				end
				S_WAIT: begin
					if (kres.done) begin
						priority if (kres.coincident) begin
							sat_q   <= 1'b1;
							state_q <= S_DONE;
						end else if (acc > (pnd_pkg::NUM_W + 1)'(32'hFFFF_FFFF)) begin
							sat_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							sum_q   <= acc[pnd_pkg::DENS_W-1:0];
							j_q     <= j_q + 1'b1;
							state_q <= S_NEXT;
						end
					end
				end
				S_DONE: begin
					done_q      <= 1'b1;
					density_q   <= sat_q ? '1 : sum_q;
					saturated_q <= sat_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign queried_index = idx_q;
	assign density       = density_q;
	assign saturated     = saturated_q;

`ifndef SYNTHESIS
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == pnd_pkg::OP_WRITE |=> !busy)
		else $error("write transfer left the block busy");
	a_done_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_DONE)) else $error("result without query");
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && saturated_q |-> density_q == '1) else $error("saturation not at full scale");
	a_kernel_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		kres.done |-> state_q == S_WAIT) else $error("kernel result outside wait");
`endif

endmodule

`default_nettype wire

/* design/pnd_ram.sv */
// ----------------------------------------------------------------------------
// pnd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pnd_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = pnd_pkg::PARTICLES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/pnd_kernel.sv */
// ----------------------------------------------------------------------------
// pnd_kernel: distance and kernel weight unit
// Takes a squared distance, forms floor(sqrt) one bit a cycle, then divides
// the radius by it one quotient bit a cycle to give re/dis - 1 in Q31.16.
// ----------------------------------------------------------------------------
`default_nettype none

module pnd_kernel (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pnd_pkg::D2_W-1:0]      d2,
	input  wire logic [pnd_pkg::RAD_W-1:0]     re,
	output pnd_pkg::kres_t                     res
);

	typedef enum logic [1:0] {K_IDLE, K_SQRT, K_CHECK, K_DIV} kstate_t;

	kstate_t                           state_q;
	logic [5:0]                        cnt_q;
	logic [pnd_pkg::D2_W-1:0]          v_q;
	logic [pnd_pkg::ROOT_W+2:0]        srem_q;
	logic [pnd_pkg::ROOT_W-1:0]        root_q;
	logic [pnd_pkg::RAD_W-1:0]         dvs_q;
	logic [pnd_pkg::NUM_W-1:0]         num_q;
	logic [pnd_pkg::RAD_W:0]           drem_q;
	logic [pnd_pkg::NUM_W-1:0]         quo_q;
	pnd_pkg::kres_t                    res_q;

	logic [pnd_pkg::ROOT_W+2:0]        srem_sh;
	logic [pnd_pkg::ROOT_W+2:0]        trial;
	logic [pnd_pkg::RAD_W:0]           drem_sh;

	// One square root digit and one quotient digit
	always_comb begin
		srem_sh = {srem_q[pnd_pkg::ROOT_W:0], v_q[pnd_pkg::D2_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		drem_sh = {drem_q[pnd_pkg::RAD_W-1:0], num_q[pnd_pkg::NUM_W-1]};
	end

	// Sequence the root then the divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			cnt_q   <= '0;
			res_q   <= '0;
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				K_IDLE: begin
					if (start) begin
						v_q     <= d2;
						srem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= K_SQRT;
					end
				end
				K_SQRT: begin
					v_q <= {v_q[pnd_pkg::D2_W-3:0], 2'b00};
					if (srem_sh >= trial) begin
						srem_q <= srem_sh - trial;
						root_q <= {root_q[pnd_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						root_q <= {root_q[pnd_pkg::ROOT_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(pnd_pkg::SQRT_STEPS - 1)) begin
						state_q <= K_CHECK;
					end
				end
				K_CHECK: begin
					priority if (root_q >= {1'b0, re}) begin
						res_q   <= '{done: 1'b1, coincident: 1'b0, weight: '0};
						state_q <= K_IDLE;
					end else if (root_q == '0) begin
						res_q   <= '{done: 1'b1, coincident: 1'b1, weight: '0};
						state_q <= K_IDLE;
					end else begin
						dvs_q   <= root_q[pnd_pkg::RAD_W-1:0];
						num_q   <= {re, 16'b0};
						drem_q  <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= K_DIV;
					end
				end
				K_DIV: begin
					num_q <= {num_q[pnd_pkg::NUM_W-2:0], 1'b0};
					if (drem_sh >= {1'b0, dvs_q}) begin
						drem_q <= drem_sh - {1'b0, dvs_q};
						quo_q  <= {quo_q[pnd_pkg::NUM_W-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quo_q  <= {quo_q[pnd_pkg::NUM_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(pnd_pkg::DIV_STEPS - 1)) begin
						res_q.done       <= 1'b1;
						res_q.coincident <= 1'b0;
						res_q.weight     <= {quo_q[pnd_pkg::NUM_W-2:0],
							(drem_sh >= {1'b0, dvs_q})} - pnd_pkg::ONE_Q16;
						state_q <= K_IDLE;
					end
				end
				default: state_q <= K_IDLE;
			endcase
		end
	end

	assign res = res_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done |=> !res_q.done) else $error("kernel done longer than a cycle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done |-> state_q == K_IDLE) else $error("kernel done while busy");
	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done && res_q.coincident |-> res_q.weight == '0)
		else $error("coincident result with weight");
`endif

endmodule

`default_nettype wire
